FILE: rtl/lsfr_pkg.sv
// ----------------------------------------------------------------------------
// lsfr_pkg - shared types and constants for the serial LCD refresh block
// Holds the queue entry format, command codes and the per-step byte encoder.
// ----------------------------------------------------------------------------
package lsfr_pkg;

    // Row address carried in the queue; covers up to 64 lines.
    localparam int ROW_MAX_W = 6;

    // Sync bytes and display commands.
    localparam logic [7:0] SYNC_CMD  = 8'hF8;
    localparam logic [7:0] SYNC_DATA = 8'hFA;
    localparam logic [7:0] CMD_EXT   = 8'h34;
    localparam logic [7:0] CMD_GFX   = 8'h36;
    localparam logic [7:0] CMD_ADDR  = 8'h80;
    localparam logic [7:0] NIB_MASK  = 8'hF0;

    // Output sequence of one line-start request: four commands of three bytes,
    // the data sync byte, then the two data nibbles.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FIRST   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_EXT_SY  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_EXT_HI  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_EXT_LO  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ROW_SY  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ROW_HI  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ROW_LO  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_COL_SY  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_COL_HI  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_COL_LO  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_GFX_SY  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_GFX_HI  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_GFX_LO  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_DSYNC   = 4'd12;
    localparam logic [STEP_W-1:0] STEP_DATA_HI = 4'd13;
    localparam logic [STEP_W-1:0] STEP_DATA_LO = 4'd14;

    // One request as classified by the front end.
    typedef struct packed {
        logic [7:0]           pixel_byte;
        logic                 line_start;
        logic                 line_end;
        logic [ROW_MAX_W-1:0] row;
    } t_item;

    // One output byte and its select release, before the last flag is added.
    typedef struct packed {
        logic [7:0] spi_byte;
        logic       end_of_select;
    } t_emit;

    function automatic logic [7:0] lsfr_hi(input logic [7:0] c);
        return c & NIB_MASK;
    endfunction

    function automatic logic [7:0] lsfr_lo(input logic [7:0] c);
        return {c[3:0], 4'h0};
    endfunction

    // Byte and select release for a given step of a request.
    function automatic t_emit lsfr_step_byte(input logic [STEP_W-1:0] step,
                                             input t_item it);
        t_emit      e;
        logic [7:0] row_cmd;
        row_cmd = CMD_ADDR | 8'(it.row);
        e.end_of_select = 1'b0;
        case (step)
            STEP_EXT_SY, STEP_ROW_SY, STEP_COL_SY, STEP_GFX_SY: begin
                e.spi_byte = SYNC_CMD;
            end
            STEP_EXT_HI: e.spi_byte = lsfr_hi(CMD_EXT);
            STEP_EXT_LO: begin
                e.spi_byte      = lsfr_lo(CMD_EXT);
                e.end_of_select = 1'b1;
            end
            STEP_ROW_HI: e.spi_byte = lsfr_hi(row_cmd);
            STEP_ROW_LO: begin
                e.spi_byte      = lsfr_lo(row_cmd);
                e.end_of_select = 1'b1;
            end
            STEP_COL_HI: e.spi_byte = lsfr_hi(CMD_ADDR);
            STEP_COL_LO: begin
                e.spi_byte      = lsfr_lo(CMD_ADDR);
                e.end_of_select = 1'b1;
            end
            STEP_GFX_HI: e.spi_byte = lsfr_hi(CMD_GFX);
            STEP_GFX_LO: begin
                e.spi_byte      = lsfr_lo(CMD_GFX);
                e.end_of_select = 1'b1;
            end
            STEP_DSYNC:   e.spi_byte = SYNC_DATA;
            STEP_DATA_HI: e.spi_byte = lsfr_hi(it.pixel_byte);
            STEP_DATA_LO: begin
                e.spi_byte      = lsfr_lo(it.pixel_byte);
                e.end_of_select = it.line_end;
            end
            default: e.spi_byte = SYNC_CMD;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/lsfr_front.sv
// ----------------------------------------------------------------------------
// lsfr_front - raster position tracking
// Tags each accepted frame byte with line start, line end and row address.
// ----------------------------------------------------------------------------
module lsfr_front #(
    parameter int LINE_BYTES  = 18,
    parameter int FRAME_LINES = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_pixel_byte,
    input  logic            i_frame_start,
    output lsfr_pkg::t_item o_item
);

    localparam int COL_W = (LINE_BYTES  > 1) ? $clog2(LINE_BYTES)  : 1;
    localparam int ROW_W = (FRAME_LINES > 1) ? $clog2(FRAME_LINES) : 1;

    logic [COL_W-1:0] r_col, n_col, col_eff;
    logic [ROW_W-1:0] r_row, n_row, row_eff;
    logic             line_end;

    // Frame start forces row 0, column 0 before classification.
    assign col_eff  = i_frame_start ? '0 : r_col;
    assign row_eff  = i_frame_start ? '0 : r_row;
    assign line_end = (col_eff == COL_W'(LINE_BYTES - 1));

    always_comb begin
        o_item.pixel_byte = i_pixel_byte;
        o_item.line_start = (col_eff == '0);
        o_item.line_end   = line_end;
        o_item.row        = lsfr_pkg::ROW_MAX_W'(row_eff);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_push) begin
            if (line_end) begin
                n_col = '0;
                n_row = (row_eff == ROW_W'(FRAME_LINES - 1)) ? '0 : row_eff + ROW_W'(1);
            end else begin
                n_col = col_eff + COL_W'(1);
                n_row = row_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

FILE: rtl/lsfr_queue.sv
// ----------------------------------------------------------------------------
// lsfr_queue - two-entry request queue
// Decouples the front end from the byte sequencer; head is slot 0.
// ----------------------------------------------------------------------------
module lsfr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lsfr_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output lsfr_pkg::t_item o_head
);

    logic [1:0]      r_count, n_count;
    lsfr_pkg::t_item r_slot0, r_slot1;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_slot0;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Payload slots: shift on pop, fill the first free slot on push.
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (i_push && (r_count == 2'd1)) begin
                r_slot0 <= i_item;
            end else begin
                r_slot0 <= r_slot1;
            end
            if (i_push && (r_count != 2'd1)) begin
                r_slot1 <= i_item;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_slot0 <= i_item;
            end else begin
                r_slot1 <= i_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/lsfr_back.sv
// ----------------------------------------------------------------------------
// lsfr_back - byte sequencer
// Walks each queued request through its output bytes, one per cycle while the consumer keeps popping.
// ----------------------------------------------------------------------------
module lsfr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  lsfr_pkg::t_item      i_head,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_spi_byte,
    output logic                 o_end_of_select,
    output logic                 o_last
);

    logic                          r_active, n_active;
    logic [lsfr_pkg::STEP_W-1:0]   r_step, n_step, cur_step;
    logic                          r_valid, n_valid;
    logic [7:0]                    r_spi_byte;
    logic                          r_eos, r_last;
    logic                          emit;
    lsfr_pkg::t_emit               e;

    // Start a fresh request at the first command or straight at the data.
    assign cur_step = r_active ? r_step :
                      (i_head.line_start ? lsfr_pkg::STEP_FIRST : lsfr_pkg::STEP_DATA_HI);
    assign emit     = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop  = emit && (cur_step == lsfr_pkg::STEP_DATA_LO);
    assign e        = lsfr_pkg::lsfr_step_byte(cur_step, i_head);

    always_comb begin
        n_active = r_active;
        n_step   = r_step;
        n_valid  = r_valid;
        if (i_pop && r_valid) begin
            n_valid = 1'b0;
        end
        if (emit) begin
            n_valid = 1'b1;
            if (cur_step == lsfr_pkg::STEP_DATA_LO) begin
                n_active = 1'b0;
            end else begin
                n_active = 1'b1;
                n_step   = cur_step + lsfr_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_spi_byte <= e.spi_byte;
            r_eos      <= e.end_of_select;
            r_last     <= (cur_step == lsfr_pkg::STEP_DATA_LO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_step   <= lsfr_pkg::STEP_FIRST;
            r_valid  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_step   <= n_step;
            r_valid  <= n_valid;
        end
    end

    assign o_empty         = !r_valid;
    assign o_spi_byte      = r_spi_byte;
    assign o_end_of_select = r_eos;
    assign o_last          = r_last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_step <= lsfr_pkg::STEP_DATA_LO))
        else $error("sequencer step out of range");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> !r_active && r_valid && r_last)
        else $error("request retired without last byte");

    a_active_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !i_q_empty)
        else $error("sequencer mid-request with empty queue");

    a_cmd_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_eos && !r_last) |-> (r_spi_byte[3:0] == 4'h0))
        else $error("select released on a non-nibble byte");

endmodule

FILE: rtl/lcd_serial_frame_refresh.sv
// ----------------------------------------------------------------------------
// lcd_serial_frame_refresh - serial byte stream for a graphics LCD refresh
// Turns raster-order frame bytes into framed command and data bytes.
// ----------------------------------------------------------------------------
// Push frame bytes in raster order, LINE_BYTES per line and FRAME_LINES lines
// per frame; pop the byte stream for the display's serial port. A byte that
// opens a line produces 15 output bytes (four commands of sync, high nibble and
// low nibble each under its own select, the data sync byte, then the pixel
// nibbles); any other byte produces 2. The back-end sequencer moves at most one
// output byte per cycle, so a line yields 13 + 2 * LINE_BYTES output bytes. The
// input side sits behind a two-entry queue and accepts up to two requests,
// counting the one in the sequencer, while it or the consumer stalls. Assert
// frame_start with a byte to force it to row 0, column 0. end_of_select marks
// the byte after which chip select is released; last marks the final byte
// caused by one pushed request. No clearing pass: the block takes requests as
// soon as reset is released.
// ----------------------------------------------------------------------------
module lcd_serial_frame_refresh #(
    parameter int LINE_BYTES  = 18,
    parameter int FRAME_LINES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request side
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_pixel_byte,
    input  logic       i_frame_start,
    // result side
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_spi_byte,
    output logic       o_end_of_select,
    output logic       o_last
);

    lsfr_pkg::t_item item_in;
    lsfr_pkg::t_item head;
    logic            accept;
    logic            q_empty;
    logic            q_pop;

    // Accept a request whenever the queue has room.
    assign accept = i_push && !o_full;

    // Front: track row and column, classify each byte.
    lsfr_front #(
        .LINE_BYTES  (LINE_BYTES),
        .FRAME_LINES (FRAME_LINES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (accept),
        .i_pixel_byte  (i_pixel_byte),
        .i_frame_start (i_frame_start),
        .o_item        (item_in)
    );

    // Queue: hold classified requests between the two sides.
    lsfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (item_in),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // Back: advance through the bytes of the head request into the output register.
    lsfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_head          (head),
        .o_q_pop         (q_pop),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_spi_byte      (o_spi_byte),
        .o_end_of_select (o_end_of_select),
        .o_last          (o_last)
    );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for lcd_serial_frame_refresh
// Pushes frame bytes in raster order and predicts the framed serial byte
// stream, with the command preamble at each line start, the data sync byte and
// the nibble pairs. Every popped byte is checked against the predicted stream,
// while both queue sides idle in random bursts until late in the run.
// ----------------------------------------------------------------------------
module tb;

    localparam int LINE_BYTES  = 18;
    localparam int FRAME_LINES = 32;
    localparam int RAND_ITEMS  = 337;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 32;

    // One byte of the serial stream as it leaves the block.
    typedef struct packed {
        logic [7:0] spi_byte;
        logic       end_of_select;
        logic       last;
    } t_spi_out;

    // Tracks the line and column of the next frame byte and holds the serial
    // bytes still owed by the block, oldest first.
    class frame_stream_board;
        t_spi_out   spi_bytes_due[$];
        logic [5:0] row_at;
        logic [4:0] col_at;
        int         errors;

        function new();
            row_at = '0;
            col_at = '0;
            errors = 0;
        endfunction

        function void owe_byte(logic [7:0] b, logic eos);
            t_spi_out o;
            o.spi_byte      = b;
            o.end_of_select = eos;
            o.last          = 1'b0;
            spi_bytes_due.push_back(o);
        endfunction

        // A command goes out as sync, high nibble, low nibble, then drops select.
        function void owe_command(logic [7:0] cmd);
            owe_byte(lsfr_pkg::SYNC_CMD, 1'b0);
            owe_byte(cmd & lsfr_pkg::NIB_MASK, 1'b0);
            owe_byte({cmd[3:0], 4'h0}, 1'b1);
        endfunction

        function void note_request(logic [7:0] pb, logic fs);
            t_spi_out tail;
            logic     line_end;
            if (fs) begin
                row_at = '0;
                col_at = '0;
            end
            if (row_at >= FRAME_LINES) row_at = '0;
            if (col_at >= LINE_BYTES) col_at = '0;
            if (col_at == '0) begin
                owe_command(lsfr_pkg::CMD_EXT);
                owe_command(lsfr_pkg::CMD_ADDR | 8'({1'b0, row_at}));
                owe_command(lsfr_pkg::CMD_ADDR);
                owe_command(lsfr_pkg::CMD_GFX);
                owe_byte(lsfr_pkg::SYNC_DATA, 1'b0);
            end
            line_end = (int'(col_at) + 1 >= LINE_BYTES);
            owe_byte(pb & lsfr_pkg::NIB_MASK, 1'b0);
            owe_byte({pb[3:0], 4'h0}, line_end);
            tail = spi_bytes_due.pop_back();
            tail.last = 1'b1;
            spi_bytes_due.push_back(tail);
            if (line_end) begin
                col_at = '0;
                row_at = row_at + 6'd1;
                if (row_at >= FRAME_LINES) row_at = '0;
            end else begin
                col_at = col_at + 5'd1;
            end
        endfunction

        function void check_result(logic [7:0] b, logic eos, logic lst);
            t_spi_out want;
            if (spi_bytes_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: unexpected byte %02h eos %0b last %0b", b, eos, lst);
                return;
            end
            want = spi_bytes_due.pop_front();
            if (want.spi_byte !== b || want.end_of_select !== eos || want.last !== lst) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: expected byte %02h eos %0b last %0b, got %02h %0b %0b",
                             want.spi_byte, want.end_of_select, want.last, b, eos, lst);
            end
        endfunction

        function int pending();
            return spi_bytes_due.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_push;
    logic       o_full;
    logic [7:0] i_pixel_byte;
    logic       i_frame_start;
    logic       o_empty;
    logic       i_pop;
    logic [7:0] o_spi_byte;
    logic       o_end_of_select;
    logic       o_last;

    frame_stream_board board;
    bit  in_run;
    bit  bursts_on;
    int  cycles;

    lcd_serial_frame_refresh #(
        .LINE_BYTES (LINE_BYTES),
        .FRAME_LINES(FRAME_LINES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_pixel_byte   (i_pixel_byte),
        .i_frame_start  (i_frame_start),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_spi_byte     (o_spi_byte),
        .o_end_of_select(o_end_of_select),
        .o_last         (o_last)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Hard stop: the slowest legal run (15 bytes per request, each behind the
    // longest pop stall, plus the longest push gap) stays well below this.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL lcd_serial_frame_refresh");
            $finish;
        end
    end

    // Check every byte popped from the block against the predicted stream.
    always @(posedge i_clk) begin
        if (in_run && i_pop && !o_empty)
            board.check_result(o_spi_byte, o_end_of_select, o_last);
    end

    // Drive pop: hold it low for random stretches while bursts are enabled,
    // otherwise keep popping every cycle.
    initial begin
        int stall;
        i_pop = 1'b0;
        wait (in_run);
        forever begin
            @(negedge i_clk);
            if (bursts_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 13);
                i_pop <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // Push one request and hold it until the block takes it. Called at a
    // falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [7:0] pb, input logic fs);
        int gap;
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push        <= 1'b1;
        i_pixel_byte  <= pb;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_full);
        board.note_request(pb, fs);
        @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] line0 [LINE_BYTES];
        int n_rand;
        int k;

        board         = new();
        in_run        = 1'b0;
        bursts_on     = 1'b1;
        cycles        = 0;
        i_rst_n       = 1'b0;
        i_push        = 1'b0;
        i_pixel_byte  = '0;
        i_frame_start = 1'b0;

        // Hold reset, then release it at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        in_run  <= 1'b1;
        @(negedge i_clk);

        // Directed: a full first line of corner patterns, starting with a
        // resync, so the line end releases select and row 1 follows.
        line0 = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'hA5, 8'h5A, 8'h01, 8'h80,
                  8'h10, 8'h08, 8'h7F, 8'hFE, 8'h33, 8'hCC, 8'h55, 8'hAA,
                  8'hE7, 8'h18};
        for (k = 0; k < LINE_BYTES; k++)
            send_request(line0[k], k == 0);
        send_request(8'h81, 1'b0);
        send_request(8'h7E, 1'b0);
        // Resync in mid-line, then again right after it.
        send_request(8'h3C, 1'b1);
        send_request(8'hC3, 1'b1);
        send_request(8'h99, 1'b0);

        // Random: a long run from a resync across many lines, so the row
        // address climbs well into the frame; the content of every byte is random.
        n_rand = RAND_ITEMS;
        for (k = 0; k < n_rand; k++)
            send_request(8'($urandom_range(0, 255)), k == 0);

        // Noise: resyncs land anywhere within a line; drop bursts after the first 20 requests.
        for (k = 0; k < 60; k++) begin
            if (k == 20) bursts_on = 1'b0;
            send_request(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        end
        i_push <= 1'b0;

        // Drain what is still owed, then idle a little to catch stray bytes.
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS lcd_serial_frame_refresh");
        end else begin
            $display("FAIL lcd_serial_frame_refresh");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/lsfr_pkg.sv
rtl/lsfr_front.sv
rtl/lsfr_queue.sv
rtl/lsfr_back.sv
rtl/lcd_serial_frame_refresh.sv
tb/tb.sv
